// ===== src/babc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babc_pkg
// Shared constants, codes and types of the bit-aligned block copy.
// ----------------------------------------------------------------------------
package babc_pkg;

  localparam int STORE_WORDS = 1024;
  localparam int WORD_BITS   = 64;
  localparam int OFF_W       = $clog2(WORD_BITS);
  localparam int IDX_W       = $clog2(STORE_WORDS);
  localparam int TOTAL_BITS  = STORE_WORDS * WORD_BITS;

  localparam int CMD_W       = 2;
  localparam int WINDEX_W    = 10;
  localparam int BIT_ADDR_W  = 16;
  localparam int COUNT_W     = 17;
  // wide enough for any end address of a copy
  localparam int BIT_W       = COUNT_W + 1;
  localparam int WIDX_W      = BIT_W - OFF_W;
  localparam int QW          = BIT_ADDR_W + 1 - OFF_W;
  localparam int SW          = WIDX_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_COPY  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PRIME,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic                 load;
    logic                 asc;
    logic [OFF_W-1:0]     shift;
    logic [WORD_BITS-1:0] mask;
  } merge_ctl_t;

endpackage

// ===== src/babc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babc_if
// Request and response channels of the bit-aligned block copy.
// ----------------------------------------------------------------------------
interface babc_cmd_if
  import babc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [WINDEX_W-1:0]   word_index;
  logic [WORD_BITS-1:0]  write_data;
  logic [BIT_ADDR_W-1:0] dest_bit;
  logic [BIT_ADDR_W-1:0] source_bit;
  logic [COUNT_W-1:0]    bit_count;

  modport source (
    output valid, command, word_index, write_data, dest_bit, source_bit, bit_count,
    input  ready
  );
  modport sink (
    input  valid, command, word_index, write_data, dest_bit, source_bit, bit_count,
    output ready
  );
endinterface

interface babc_rsp_if
  import babc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] read_data;
  logic                 status;

  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

// ===== src/babc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babc_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module babc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== src/babc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babc_merge
// Funnel shifter over a two-word source window and edge-mask merge.
// ----------------------------------------------------------------------------
module babc_merge
  import babc_pkg::*;
(
  input  logic                 clk_i,
  input  merge_ctl_t           ctl_i,
  input  logic [WORD_BITS-1:0] src_rdata_i,
  input  logic [WORD_BITS-1:0] dst_rdata_i,
  output logic [WORD_BITS-1:0] wdata_o
);

  logic [WORD_BITS-1:0]   prev_q;
  logic [2*WORD_BITS-1:0] window;
  logic [2*WORD_BITS-1:0] shifted;
  logic [WORD_BITS-1:0]   src_bits;

  // ascending walks fetch the upper word of the window, descending the lower
  always_comb begin
    if (ctl_i.asc) begin
      window = {src_rdata_i, prev_q};
    end else begin
      window = {prev_q, src_rdata_i};
    end
    shifted  = window >> ctl_i.shift;
    src_bits = shifted[WORD_BITS-1:0];
  end

  assign wdata_o = (dst_rdata_i & ~ctl_i.mask) | (src_bits & ctl_i.mask);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      prev_q <= src_rdata_i;
    end
  end

endmodule

// ===== src/babc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babc_ctrl
// Request decode, copy sequencer, RAM addressing and response register.
// ----------------------------------------------------------------------------
module babc_ctrl
  import babc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  babc_cmd_if.sink             cmd_i,
  babc_rsp_if.source           rsp_o,
  output logic                 we_o,
  output logic [IDX_W-1:0]     waddr_o,
  output logic [WORD_BITS-1:0] wdata_o,
  output logic [IDX_W-1:0]     raddr0_o,
  output logic [IDX_W-1:0]     raddr1_o,
  input  logic [WORD_BITS-1:0] rdata1_i,
  input  logic [WORD_BITS-1:0] merge_wdata_i,
  output merge_ctl_t           merge_ctl_o
);

  state_e state_q, state_d;

  logic [WIDX_W-1:0]    w_q, w_d, w_last_q, w_last_d;
  logic [WIDX_W-1:0]    wd0_q, wd0_d, wd1_q, wd1_d;
  logic [OFF_W-1:0]     lo_q, lo_d, hi_q, hi_d, sh_q, sh_d;
  logic                 asc_q, asc_d;
  logic [IDX_W-1:0]     sa_q, sa_d;
  logic                 s1_load_q, s1_load_d, s1_wr_q, s1_wr_d;
  logic [WIDX_W-1:0]    s1_w_q, s1_w_d;
  logic [WORD_BITS-1:0] s1_mask_q, s1_mask_d;
  logic                 rd_ok_q, rd_ok_d;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0] out_data_q, out_data_d;
  logic                 out_status_q, out_status_d;

  cmd_e                    cmd;
  logic                    accept;
  logic                    idx_ok;
  logic [BIT_W-1:0]        dst_end, src_end, dst_last;
  logic                    range_err, zero_cnt;
  logic signed [BIT_ADDR_W:0] delta;
  logic signed [QW-1:0]    q;
  logic signed [SW-1:0]    q_ext, sa_sum;
  logic                    asc_new;
  logic [WIDX_W-1:0]       wd0_new, wd1_new;
  logic [OFF_W-1:0]        mask_lo, mask_hi;
  logic [WORD_BITS-1:0]    run_mask;
  logic [IDX_W-1:0]        sa_step;
  logic                    out_load;
  logic [WORD_BITS-1:0]    load_data;
  logic                    load_status;

  assign cmd          = cmd_e'(cmd_i.command);
  assign cmd_i.ready  = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept       = cmd_i.valid && cmd_i.ready;
  assign idx_ok       = 32'(cmd_i.word_index) < 32'(STORE_WORDS);

  // copy geometry, worked out on the accepting cycle
  always_comb begin
    dst_end   = BIT_W'(cmd_i.dest_bit) + BIT_W'(cmd_i.bit_count);
    src_end   = BIT_W'(cmd_i.source_bit) + BIT_W'(cmd_i.bit_count);
    dst_last  = dst_end - BIT_W'(1);
    range_err = (32'(dst_end) > 32'(TOTAL_BITS)) || (32'(src_end) > 32'(TOTAL_BITS));
    zero_cnt  = (cmd_i.bit_count == '0);
    delta     = $signed({1'b0, cmd_i.source_bit}) - $signed({1'b0, cmd_i.dest_bit});
    q         = QW'(delta >>> OFF_W);
    q_ext     = SW'(q);
    asc_new   = (cmd_i.source_bit >= cmd_i.dest_bit);
    wd0_new   = WIDX_W'(cmd_i.dest_bit[BIT_ADDR_W-1:OFF_W]);
    wd1_new   = dst_last[BIT_W-1:OFF_W];
    // first source word: lower edge when ascending, upper edge when descending
    if (asc_new) begin
      sa_sum = $signed(SW'(wd0_new)) + q_ext;
    end else begin
      sa_sum = $signed(SW'(wd1_new)) + q_ext + $signed(SW'(1));
    end
  end

  // edge masks keep destination bits outside the range
  always_comb begin
    mask_lo  = (w_q == wd0_q) ? lo_q : '0;
    mask_hi  = (w_q == wd1_q) ? hi_q : '1;
    run_mask = ({WORD_BITS{1'b1}} << mask_lo) & ({WORD_BITS{1'b1}} >> (~mask_hi));
    sa_step  = asc_q ? (sa_q + IDX_W'(1)) : (sa_q - IDX_W'(1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_READ) begin
            state_d = ST_READ;
          end else if ((cmd == CMD_COPY) && !zero_cnt && !range_err) begin
            state_d = ST_PRIME;
          end
        end
      end
      ST_READ:  state_d = ST_IDLE;
      ST_PRIME: state_d = ST_RUN;
      ST_RUN: begin
        if (w_q == w_last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    w_d         = w_q;
    w_last_d    = w_last_q;
    wd0_d       = wd0_q;
    wd1_d       = wd1_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    sh_d        = sh_q;
    asc_d       = asc_q;
    sa_d        = sa_q;
    rd_ok_d     = rd_ok_q;
    s1_load_d   = 1'b0;
    s1_wr_d     = 1'b0;
    s1_w_d      = w_q;
    s1_mask_d   = run_mask;
    we_o        = 1'b0;
    waddr_o     = IDX_W'(s1_w_q);
    wdata_o     = merge_wdata_i;
    raddr1_o    = IDX_W'(w_q);
    out_load    = 1'b0;
    load_data   = '0;
    load_status = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        raddr1_o = IDX_W'(cmd_i.word_index);
        if (accept) begin
          unique case (cmd)
            CMD_WRITE: begin
              we_o     = idx_ok;
              waddr_o  = IDX_W'(cmd_i.word_index);
              wdata_o  = cmd_i.write_data;
              out_load = 1'b1;
            end
            CMD_READ: begin
              rd_ok_d = idx_ok;
            end
            CMD_COPY: begin
              if (zero_cnt) begin
                out_load = 1'b1;
              end else if (range_err) begin
                out_load    = 1'b1;
                load_status = 1'b1;
              end else begin
                asc_d    = asc_new;
                wd0_d    = wd0_new;
                wd1_d    = wd1_new;
                lo_d     = cmd_i.dest_bit[OFF_W-1:0];
                hi_d     = dst_last[OFF_W-1:0];
                sh_d     = delta[OFF_W-1:0];
                sa_d     = IDX_W'(sa_sum);
                w_d      = asc_new ? wd0_new : wd1_new;
                w_last_d = asc_new ? wd1_new : wd0_new;
              end
            end
            CMD_NONE: begin
              out_load = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load  = 1'b1;
        load_data = rd_ok_q ? rdata1_i : '0;
      end
      ST_PRIME: begin
        s1_load_d = 1'b1;
        sa_d      = sa_step;
      end
      ST_RUN: begin
        // one destination word issued per cycle, written back in the next cycle
        s1_load_d = 1'b1;
        s1_wr_d   = 1'b1;
        sa_d      = sa_step;
        w_d       = asc_q ? (w_q + WIDX_W'(1)) : (w_q - WIDX_W'(1));
        we_o      = s1_wr_q;
      end
      ST_DRAIN: begin
        we_o     = s1_wr_q;
        out_load = 1'b1;
      end
      default: begin
        we_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_load || (out_valid_q && !rsp_o.ready);
    out_data_d   = out_load ? load_data : out_data_q;
    out_status_d = out_load ? load_status : out_status_q;
  end

  assign raddr0_o          = sa_q;
  assign merge_ctl_o.load  = s1_load_q;
  assign merge_ctl_o.asc   = asc_q;
  assign merge_ctl_o.shift = sh_q;
  assign merge_ctl_o.mask  = s1_mask_q;

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;
  assign rsp_o.status    = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s1_load_q   <= 1'b0;
      s1_wr_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_load_q   <= s1_load_d;
      s1_wr_q     <= s1_wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q          <= w_d;
    w_last_q     <= w_last_d;
    wd0_q        <= wd0_d;
    wd1_q        <= wd1_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    sh_q         <= sh_d;
    asc_q        <= asc_d;
    sa_q         <= sa_d;
    rd_ok_q      <= rd_ok_d;
    s1_w_q       <= s1_w_d;
    s1_mask_q    <= s1_mask_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

endmodule

// ===== src/bit_aligned_block_copy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_aligned_block_copy
// Word store with word read/write and bit-range copy through a funnel shifter.
//
//   port   | dir | contents
//   -------+-----+----------------------------------------------------------
//   cmd_i  | in  | command, word_index, write_data, dest_bit, source_bit,
//          |     | bit_count
//   rsp_o  | out | read_data, status
//
// Writes land on the accepting cycle, reads pass a registered RAM port, copies
// walk prime, run and drain states: the store RAM serves one source and one
// destination read and one write-back each cycle. Copies walk upward when the
// source lies at or above the destination and downward otherwise. Out-of-range
// and empty copies answer without a walk. The store is not cleared at reset
// and needs no clearing pass. A stalled response holds the next request back.
// ----------------------------------------------------------------------------
module bit_aligned_block_copy
  import babc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  babc_cmd_if.sink   cmd_i,
  babc_rsp_if.source rsp_o
);

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [IDX_W-1:0]     raddr0;
  logic [IDX_W-1:0]     raddr1;
  logic [WORD_BITS-1:0] rdata0;
  logic [WORD_BITS-1:0] rdata1;
  logic [WORD_BITS-1:0] merge_wdata;
  merge_ctl_t           merge_ctl;

  babc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .rsp_o         (rsp_o),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr0_o      (raddr0),
    .raddr1_o      (raddr1),
    .rdata1_i      (rdata1),
    .merge_wdata_i (merge_wdata),
    .merge_ctl_o   (merge_ctl)
  );

  babc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  babc_merge u_merge (
    .clk_i       (clk_i),
    .ctl_i       (merge_ctl),
    .src_rdata_i (rdata0),
    .dst_rdata_i (rdata1),
    .wdata_o     (merge_wdata)
  );

endmodule
